// ===== hw/rtl/time_sorted_event_queue_assert.svh =====
// Assertion macros for the event queue RTL.
// Depends on nothing; included by the top-level queue file, the only one that carries assertions.
`ifndef TIME_SORTED_EVENT_QUEUE_ASSERT_SVH
`define TIME_SORTED_EVENT_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSEQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("event queue assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("event queue assertion failed");

`endif

// ===== hw/rtl/tseq_pkg.sv =====
// Types and codes shared by the event queue cells and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package tseq_pkg;

  localparam int TIME_W  = 16;
  localparam int JOB_W   = 16;
  localparam int FILL_W  = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] time_stamp;
    logic [JOB_W-1:0]  job;
  } entry_t;

  typedef struct packed {
    logic ins_en;
    logic pop_en;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/tseq_cell.sv =====
// One slot of the sorted shift-register queue.
// Depends on tseq_pkg for the entry and control types.
`timescale 1ns / 1ps

module tseq_cell
  import tseq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  entry_t     new_entry,
  input  entry_t     prev_entry,
  input  logic       prev_take,
  input  entry_t     next_entry,
  output entry_t     entry,
  output logic       take
);

  entry_t entry_r;
  entry_t entry_nxt;

  // A free slot or a later timestamp marks the slot as at or past the
  // insert point; equal times stay put so arrival order is kept.
  assign take = !occupied || (entry_r.time_stamp > new_entry.time_stamp);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.pop_en) begin
      entry_nxt = next_entry;
    end else if (ctrl.ins_en) begin
      if (prev_take) begin
        entry_nxt = prev_entry;
      end else if (take) begin
        entry_nxt = new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== hw/rtl/time_sorted_event_queue.sv =====
// A result strobe follows in the cycle after each accepted transaction.
// Throughput: one insert or pop per cycle; busy stays low, since every slot
// compares against the new time in parallel and shifts in the same cycle.
// Reset (synchronous, active low) empties the queue by clearing the count;
// slot contents are left as they are. The receiver cannot stall the results.
`timescale 1ns / 1ps

module time_sorted_event_queue
  import tseq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_opcode,
  input  logic              in_event_kind,
  input  logic [TIME_W-1:0] in_event_time,
  input  logic [JOB_W-1:0]  in_job_id,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic              out_kind,
  output logic [TIME_W-1:0] out_time,
  output logic [JOB_W-1:0]  out_job_id,
  output logic [FILL_W-1:0] out_fill_level
);

`include "time_sorted_event_queue_assert.svh"

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  logic          accept;
  logic          is_insert;
  logic          is_pop;
  logic          full;
  logic          empty;
  cell_ctrl_t    ctrl;
  entry_t        new_entry;
  entry_t        cell_entry [QUEUE_DEPTH];
  logic          cell_take  [QUEUE_DEPTH];

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r, out_status_nxt;
  entry_t        out_entry_r, out_entry_nxt;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign is_insert = (opcode_t'(in_opcode) == OP_INSERT);
  assign is_pop    = (opcode_t'(in_opcode) == OP_POP);
  assign full      = (count_r == DEPTH_C);
  assign empty     = (count_r == '0);

  assign new_entry.kind       = in_event_kind;
  assign new_entry.time_stamp = in_event_time;
  assign new_entry.job        = in_job_id;

  assign ctrl.ins_en = accept && is_insert && !full;
  assign ctrl.pop_en = accept && is_pop && !empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_t;

    if (i == 0) begin : g_first
      assign prev_e = new_entry;
      assign prev_t = 1'b0;
    end else begin : g_mid
      assign prev_e = cell_entry[i-1];
      assign prev_t = cell_take[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_e = cell_entry[i];
    end else begin : g_inner
      assign next_e = cell_entry[i+1];
    end

    tseq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (CW'(i) < count_r),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_take  (prev_t),
      .next_entry (next_e),
      .entry      (cell_entry[i]),
      .take       (cell_take[i])
    );
  end

  always_comb begin
    count_nxt      = count_r;
    out_valid_nxt  = accept;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    if (accept) begin
      out_status_nxt = ST_DONE;
      out_entry_nxt  = '0;
      if (is_insert) begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end else begin
        if (empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          count_nxt     = count_r - CW'(1);
          out_entry_nxt = cell_entry[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_kind   = out_entry_r.kind;
  assign out_time   = out_entry_r.time_stamp;
  assign out_job_id = out_entry_r.job;

  if (CW >= FILL_W) begin : g_fill_trunc
    assign out_fill_level = count_r[FILL_W-1:0];
  end else begin : g_fill_ext
    assign out_fill_level = {{(FILL_W-CW){1'b0}}, count_r};
  end

  `TSEQ_ASSERT_NEXT(a_strobe, clk, rst_n, accept, out_valid)
  `TSEQ_ASSERT_NEXT(a_no_strobe, clk, rst_n, !accept, !out_valid)
  `TSEQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= DEPTH_C)
  `TSEQ_ASSERT_NEXT(a_full_drop, clk, rst_n, accept && is_insert && full,
                    (out_status == ST_FULL) && $stable(count_r))
  `TSEQ_ASSERT_SAME(a_zero_fields, clk, rst_n, out_valid && (out_status != ST_DONE),
                    (out_time == '0) && (out_job_id == '0) && !out_kind)

endmodule

// ===== tb/tb_time_sorted_event_queue.sv =====
// Self-checking testbench for time_sorted_event_queue: directed and random inserts and pops
// are checked against a queue model kept in the bench. Depends on tseq_pkg and the queue RTL.
`timescale 1ns / 1ps

module tb_time_sorted_event_queue;
  import tseq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    status_t           status;
    logic              kind;
    logic [TIME_W-1:0] ev_time;
    logic [JOB_W-1:0]  job;
    logic [FILL_W-1:0] fill;
  } queue_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              in_opcode = 1'b0;
  logic              in_event_kind = 1'b0;
  logic [TIME_W-1:0] in_event_time = '0;
  logic [JOB_W-1:0]  in_job_id = '0;
  logic              busy;
  logic              out_valid;
  logic [1:0]        out_status;
  logic              out_kind;
  logic [TIME_W-1:0] out_time;
  logic [JOB_W-1:0]  out_job_id;
  logic [FILL_W-1:0] out_fill_level;

  entry_t        sorted_events[$];
  queue_result_t expected_results[$];
  int            fail_count = 0;
  int            cycle_count = 0;
  bit            no_idle = 1'b0;

  time_sorted_event_queue #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_event_kind (in_event_kind),
    .in_event_time (in_event_time),
    .in_job_id     (in_job_id),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_kind      (out_kind),
    .out_time      (out_time),
    .out_job_id    (out_job_id),
    .out_fill_level(out_fill_level)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Applies one transaction to the sorted model and returns the result it should produce.
  function automatic queue_result_t apply_event(opcode_t op, logic kind,
                                                logic [TIME_W-1:0] ev_time,
                                                logic [JOB_W-1:0] job);
    queue_result_t r;
    entry_t        e;
    int            pos;
    r.status  = ST_DONE;
    r.kind    = 1'b0;
    r.ev_time = '0;
    r.job     = '0;
    if (op == OP_INSERT) begin
      if (sorted_events.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // Equal times go behind the stored ones, so ties leave in arrival order.
        pos = 0;
        while (pos < sorted_events.size() && sorted_events[pos].time_stamp <= ev_time) pos++;
        e.kind       = kind;
        e.time_stamp = ev_time;
        e.job        = job;
        sorted_events.insert(pos, e);
      end
    end else if (sorted_events.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      e         = sorted_events.pop_front();
      r.kind    = e.kind;
      r.ev_time = e.time_stamp;
      r.job     = e.job;
    end
    r.fill = FILL_W'(sorted_events.size());
    return r;
  endfunction

  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 19);
    if (no_idle || pick < 11) return 0;
    if (pick < 19) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    queue_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("out_valid: expected no result, actual status %0d", out_status);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("out_status", exp_r.status, out_status);
        check_field("out_kind", exp_r.kind, out_kind);
        check_field("out_time", exp_r.ev_time, out_time);
        check_field("out_job_id", exp_r.job, out_job_id);
        check_field("out_fill_level", exp_r.fill, out_fill_level);
      end
    end
  end

  // Start stays high across back-to-back transactions; this task lowers it only for a gap.
  task automatic send_event(opcode_t op, logic kind, logic [TIME_W-1:0] ev_time,
                            logic [JOB_W-1:0] job);
    int gap;
    start         <= 1'b1;
    in_opcode     <= op;
    in_event_kind <= kind;
    in_event_time <= ev_time;
    in_job_id     <= job;
    do @(posedge clk); while (busy);
    expected_results.push_back(apply_event(op, kind, ev_time, job));
    gap = idle_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_pop_empty();
    send_event(OP_POP, 1'b1, 16'hFFFF, 16'hFFFF);
    send_event(OP_POP, 1'b0, 16'h0000, 16'h0000);
  endtask

  task automatic test_fill_extremes();
    send_event(OP_INSERT, 1'b1, 16'hFFFF, 16'hFFFF);
    send_event(OP_INSERT, 1'b0, 16'h0000, 16'h0000);
    send_event(OP_INSERT, 1'b0, 16'd100, 16'd1);
    send_event(OP_INSERT, 1'b1, 16'd100, 16'd2);
    send_event(OP_INSERT, 1'b0, 16'd100, 16'd3);
    send_event(OP_INSERT, 1'b1, 16'h0000, 16'hFFFF);
    send_event(OP_INSERT, 1'b0, 16'hFFFF, 16'h0000);
    repeat (DEPTH - 7)
      send_event(OP_INSERT, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 200)),
                 16'($urandom));
  endtask

  task automatic test_insert_full();
    send_event(OP_INSERT, 1'b1, 16'd50, 16'd77);
    send_event(OP_INSERT, 1'b0, 16'h0000, 16'h0000);
  endtask

  task automatic test_pop_ordered();
    repeat (4) send_event(OP_POP, 1'b1, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst;
    int mode;
    int time_mode;
    int pop_pct;
    bit paused;
    logic [TIME_W-1:0] ev_time;
    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst     = $urandom_range(10, 60);
      mode      = $urandom_range(0, 2);
      time_mode = $urandom_range(0, 2);
      no_idle   = ($urandom_range(0, 3) == 0);
      pop_pct   = (mode == 0) ? 15 : (mode == 1) ? 85 : 50;
      repeat (burst) begin
        case (time_mode)
          0: ev_time = 16'($urandom_range(0, 7));
          1: ev_time = 16'($urandom);
          default: begin
            case ($urandom_range(0, 3))
              0: ev_time = 16'h0000;
              1: ev_time = 16'h0001;
              2: ev_time = 16'hFFFE;
              default: ev_time = 16'hFFFF;
            endcase
          end
        endcase
        send_event(opcode_t'(($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_INSERT),
                   1'($urandom_range(0, 1)), ev_time, 16'($urandom));
        sent++;
      end
      // Hold the sender once midway until every outstanding result is back.
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_pop_empty();
    test_fill_extremes();
    test_insert_full();
    test_pop_ordered();
    wait_drained();
    test_random_traffic();

    wait_drained();
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("results: expected %0d more, actual 0", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tseq_pkg.sv
hw/rtl/tseq_cell.sv
hw/rtl/time_sorted_event_queue.sv
tb/tb_time_sorted_event_queue.sv
